// ===== rtl/orthpoly_pkg.sv =====
// ----------------------------------------------------------------------------
// orthpoly_pkg
// Shared types, widths and constants for the orthogonal polynomial series
// generator: kind and register codes, sequencer states, reciprocal table.
// ----------------------------------------------------------------------------
`default_nettype none

package orthpoly_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_ORDER = 31;
   localparam int DEF_FRAC_BITS = 16;

   // field widths
   localparam int VAL_W   = 32;
   localparam int ORDER_W = 5;
   localparam int KIND_W  = 2;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_ADDR_W-1:0] CSR_POLY_KIND = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_ORDER = 2'd1;
   localparam logic [ORDER_W-1:0]    TOP_ORDER_RESET = 5'd1;

   // stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - VAL_W - ORDER_W;

   // shared multiplier and accumulator
   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 48;
   localparam int XP_W    = 40;
   localparam int NUM_W   = 38;

   // clamp limits, chosen so that clamped values saturate the same way
   localparam logic signed [PROD_W-1:0] XP_MAX = PROD_W'((longint'(1) << (XP_W - 1)) - 1);
   localparam logic signed [PROD_W-1:0] XP_MIN = -(PROD_W'(longint'(1) << (XP_W - 1)));
   localparam logic signed [ACC_W-1:0]  NUM_MAX = ACC_W'((longint'(1) << (NUM_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0]  NUM_MIN = -(ACC_W'(longint'(1) << (NUM_W - 1)));
   localparam logic signed [ACC_W-1:0]  VAL_MAX = ACC_W'((longint'(1) << (VAL_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0]  VAL_MIN = -(ACC_W'(longint'(1) << (VAL_W - 1)));

   // reciprocal table, R(i) = round(2^RECIP_BITS / i)
   localparam int RECIP_BITS = 24;
   localparam int RECIP_W    = RECIP_BITS + 1;
   localparam int RECIP_ONE  = 1 << RECIP_BITS;
   localparam logic signed [PROD_W-1:0] RECIP_HALF = PROD_W'(longint'(1) << (RECIP_BITS - 1));
   localparam int RECIP_DEPTH = 1 << ORDER_W;

   localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
      RECIP_W'(0),
      RECIP_W'((RECIP_ONE + 0) / 1),
      RECIP_W'((RECIP_ONE + 1) / 2),
      RECIP_W'((RECIP_ONE + 1) / 3),
      RECIP_W'((RECIP_ONE + 2) / 4),
      RECIP_W'((RECIP_ONE + 2) / 5),
      RECIP_W'((RECIP_ONE + 3) / 6),
      RECIP_W'((RECIP_ONE + 3) / 7),
      RECIP_W'((RECIP_ONE + 4) / 8),
      RECIP_W'((RECIP_ONE + 4) / 9),
      RECIP_W'((RECIP_ONE + 5) / 10),
      RECIP_W'((RECIP_ONE + 5) / 11),
      RECIP_W'((RECIP_ONE + 6) / 12),
      RECIP_W'((RECIP_ONE + 6) / 13),
      RECIP_W'((RECIP_ONE + 7) / 14),
      RECIP_W'((RECIP_ONE + 7) / 15),
      RECIP_W'((RECIP_ONE + 8) / 16),
      RECIP_W'((RECIP_ONE + 8) / 17),
      RECIP_W'((RECIP_ONE + 9) / 18),
      RECIP_W'((RECIP_ONE + 9) / 19),
      RECIP_W'((RECIP_ONE + 10) / 20),
      RECIP_W'((RECIP_ONE + 10) / 21),
      RECIP_W'((RECIP_ONE + 11) / 22),
      RECIP_W'((RECIP_ONE + 11) / 23),
      RECIP_W'((RECIP_ONE + 12) / 24),
      RECIP_W'((RECIP_ONE + 12) / 25),
      RECIP_W'((RECIP_ONE + 13) / 26),
      RECIP_W'((RECIP_ONE + 13) / 27),
      RECIP_W'((RECIP_ONE + 14) / 28),
      RECIP_W'((RECIP_ONE + 14) / 29),
      RECIP_W'((RECIP_ONE + 15) / 30),
      RECIP_W'((RECIP_ONE + 15) / 31)
   };

   typedef enum logic [KIND_W-1:0] {
      KIND_CHEB1    = 2'd0,
      KIND_CHEB2    = 2'd1,
      KIND_LEGENDRE = 2'd2,
      KIND_LAGUERRE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MULX,
      ST_ROUND,
      ST_CHEB,
      ST_MULA,
      ST_ACCA,
      ST_ACCB,
      ST_CLAMP,
      ST_MULR,
      ST_SCALE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/orthogonal_polynomial_series.sv =====
// ----------------------------------------------------------------------------
// orthogonal_polynomial_series
// Emits P0(x)..Pm(x) of a Chebyshev, Legendre or Laguerre family for each
// Q16.16 sample by the three-term recurrence on one shared multiplier.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: sample_x
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: poly_value, order_index;
//                                        tlast: last_value; tuser: saturated
//   csr_     in   csr_we                 csr_addr, csr_wdata
//
// a request is taken only while the sequencer is idle; it then yields m+1
// results, m = min(top_order, MAX_ORDER). P0 and P1 each need only an emit;
// each higher order runs emit, multiply by x and round, then the Chebyshev
// step, or for Legendre and Laguerre a multiply, two accumulates, a clamp, a
// reciprocal multiply and a scale; the single signed multiplier's product is
// registered before use. the result register decouples the sides: a stalled
// rsp_tready holds the sequencer at its next emit. reset is synchronous and clears all control.
// ----------------------------------------------------------------------------
`default_nettype none

module orthogonal_polynomial_series
   import orthpoly_pkg::*;
#(
   parameter int MAX_ORDER = DEF_MAX_ORDER,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_DATA_W-1:0]   req_tdata,   // [31:0] sample_x
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] poly_value, [36:32] order_index
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,   // [0] saturated
   input  wire                    csr_we,
   input  wire [CSR_ADDR_W-1:0]   csr_addr,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [ORDER_W:0] MAX_ORDER_Q = (ORDER_W + 1)'(MAX_ORDER);
   localparam logic signed [ACC_W-1:0]  ONE_Q   = ACC_W'(longint'(1) << FRAC_BITS);
   localparam logic signed [PROD_W-1:0] XP_HALF = PROD_W'(longint'(1) << (FRAC_BITS - 1));

   state_type state_ff, state_in;
   kind_type  kind_ff;
   logic [ORDER_W-1:0] top_ff;

   logic signed [VAL_W-1:0]  x_ff, x_in;
   logic signed [VAL_W-1:0]  older_ff, older_in;
   logic signed [VAL_W-1:0]  newer_ff, newer_in;
   logic [ORDER_W-1:0]       step_ff, step_in;
   logic signed [XP_W-1:0]   xp_ff, xp_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic                     out_valid_ff, out_valid_in;
   logic signed [VAL_W-1:0]  out_value_ff, out_value_in;
   logic [ORDER_W-1:0]       out_order_ff, out_order_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_sat_ff, out_sat_in;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;

   logic                     req_fire, out_free, emit_fire, is_last;
   logic [ORDER_W-1:0]       order_max;
   logic signed [PROD_W-1:0] xp_round, scaled;
   logic signed [ACC_W-1:0]  xp_ext, x_ext, prev2_ext, p1_value;
   logic signed [VAL_W-1:0]  sat_value;
   logic                     sat_flag;
   logic [ORDER_W-1:0]       step_less;

   // handshake and control terms
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit_fire  = (state_ff == ST_EMIT) && out_free;
   assign order_max  = ({1'b0, top_ff} > MAX_ORDER_Q) ? MAX_ORDER_Q[ORDER_W-1:0] : top_ff;
   assign is_last    = (step_ff == order_max);
   assign step_less  = step_ff - ORDER_W'(1);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_order_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_sat_ff;

   // arithmetic helpers
   assign xp_ext    = ACC_W'(xp_ff);
   assign x_ext     = ACC_W'(x_ff);
   assign prev2_ext = ACC_W'(older_ff);
   assign xp_round  = (prod_ff + XP_HALF) >>> FRAC_BITS;
   assign scaled    = (prod_ff + RECIP_HALF) >>> RECIP_BITS;

   always_comb begin
      case (kind_ff)
         KIND_CHEB2:    p1_value = x_ext <<< 1;
         KIND_LAGUERRE: p1_value = ONE_Q - x_ext;
         default:       p1_value = x_ext;
      endcase
   end

   always_comb begin
      if (acc_ff > VAL_MAX) begin
         sat_value = VAL_MAX[VAL_W-1:0];
         sat_flag  = 1'b1;
      end else if (acc_ff < VAL_MIN) begin
         sat_value = VAL_MIN[VAL_W-1:0];
         sat_flag  = 1'b1;
      end else begin
         sat_value = acc_ff[VAL_W-1:0];
         sat_flag  = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (is_last) state_in = ST_IDLE;
               else if (step_ff == '0) state_in = ST_EMIT;
               else state_in = ST_MULX;
            end
         end
         ST_MULX:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (kind_ff == KIND_CHEB1 || kind_ff == KIND_CHEB2) state_in = ST_CHEB;
            else state_in = ST_MULA;
         end
         ST_CHEB:  state_in = ST_EMIT;
         ST_MULA:  state_in = ST_ACCA;
         ST_ACCA:  state_in = ST_ACCB;
         ST_ACCB:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_MULR;
         ST_MULR:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      x_in         = x_ff;
      older_in     = older_ff;
      newer_in     = newer_ff;
      step_in      = step_ff;
      xp_in        = xp_ff;
      acc_in       = acc_ff;
      op_a         = '0;
      op_b         = '0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_order_in = out_order_ff;
      out_last_in  = out_last_ff;
      out_sat_in   = out_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in     = req_tdata;
               newer_in = '0;
               step_in  = '0;
               acc_in   = ONE_Q;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = sat_value;
               out_order_in = step_ff;
               out_last_in  = is_last;
               out_sat_in   = sat_flag;
               older_in     = newer_ff;
               newer_in     = sat_value;
               step_in      = step_ff + ORDER_W'(1);
               // order one comes straight from x
               if (step_ff == '0) acc_in = p1_value;
            end
         end
         ST_MULX: begin
            op_a = MUL_A_W'(x_ff);
            op_b = newer_ff;
         end
         ST_ROUND: begin
            if (xp_round > XP_MAX) xp_in = XP_MAX[XP_W-1:0];
            else if (xp_round < XP_MIN) xp_in = XP_MIN[XP_W-1:0];
            else xp_in = xp_round[XP_W-1:0];
         end
         ST_CHEB: begin
            acc_in = (xp_ext <<< 1) - prev2_ext;
         end
         ST_MULA: begin
            // (2i-1) times x*P(i-1) or times P(i-1)
            op_a = (kind_ff == KIND_LEGENDRE) ? xp_ff : MUL_A_W'(newer_ff);
            op_b = MUL_B_W'({step_less, 1'b1});
         end
         ST_ACCA: begin
            acc_in = prod_ff[ACC_W-1:0] - ((kind_ff == KIND_LAGUERRE) ? xp_ext : '0);
            op_a   = MUL_A_W'(older_ff);
            op_b   = MUL_B_W'(step_less);
         end
         ST_ACCB: begin
            acc_in = acc_ff - prod_ff[ACC_W-1:0];
         end
         ST_CLAMP: begin
            if (acc_ff > NUM_MAX) acc_in = NUM_MAX;
            else if (acc_ff < NUM_MIN) acc_in = NUM_MIN;
         end
         ST_MULR: begin
            // clamped numerator fits the operand, keep its sign
            op_a = MUL_A_W'(acc_ff);
            op_b = MUL_B_W'(RECIP_TABLE[step_ff]);
         end
         ST_SCALE: begin
            acc_in = scaled[ACC_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // shared multiplier, product registered every cycle
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_CHEB1;
         top_ff       <= TOP_ORDER_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_POLY_KIND: kind_ff <= kind_type'(csr_wdata[KIND_W-1:0]);
               CSR_TOP_ORDER: top_ff  <= csr_wdata[ORDER_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      older_ff     <= older_in;
      newer_ff     <= newer_in;
      step_ff      <= step_in;
      xp_ff        <= xp_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      out_value_ff <= out_value_in;
      out_order_ff <= out_order_in;
      out_last_ff  <= out_last_in;
      out_sat_ff   <= out_sat_in;
   end

endmodule

`default_nettype wire
